// File: rtl/tfe_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tfe_pkg
// Shared widths, register map and arithmetic helpers for the three-tap
// feedback echo.
// ----------------------------------------------------------------------------
package tfe_pkg;

    localparam int SAMPLE_W           = 16;
    localparam int DELAY_W            = 10;
    localparam int NUM_TAPS           = 3;
    localparam int RING_DEPTH_DEFAULT = 1024;

    // APB register map (byte address 4*index)
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    localparam logic [1:0] REG_TAP_DELAY_ONE   = 2'd0;
    localparam logic [1:0] REG_TAP_DELAY_TWO   = 2'd1;
    localparam logic [1:0] REG_TAP_DELAY_THREE = 2'd2;

    localparam logic [DELAY_W-1:0] TAP_DELAY_ONE_RST   = 10'd100;
    localparam logic [DELAY_W-1:0] TAP_DELAY_TWO_RST   = 10'd500;
    localparam logic [DELAY_W-1:0] TAP_DELAY_THREE_RST = 10'd1000;

    // shift used by the reciprocal when delays are folded into a short ring
    localparam int RECIP_SHIFT = 20;

    // signed divide by 4, truncating toward zero
    function automatic logic signed [SAMPLE_W-1:0] div4_trunc(
        input logic signed [SAMPLE_W-1:0] val
    );
        logic signed [SAMPLE_W-1:0] adj;
        adj = val + $signed({{(SAMPLE_W-2){1'b0}}, val[SAMPLE_W-1], val[SAMPLE_W-1]});
        return adj >>> 2;
    endfunction

endpackage
`default_nettype wire

// File: rtl/three_tap_feedback_echo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// three_tap_feedback_echo
// Multi-tap feedback comb filter: three delayed outputs, each divided by 4,
// are added to the incoming sample unless it is zero; the wrapped sum is stored and output.
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake                     | payload
//  ---------+-----------+-------------------------------+---------------------
//  input    | in        | i_in_valid / o_in_stall       | i_in_sample  s16
//  output   | out       | o_out_valid / i_out_stall     | o_out_sample s16
//  config   | in        | APB psel/penable/pwrite/pready| pwdata[9:0], 3 regs
//
//  Throughput is one transaction per clock while the output is not stalled.
//  From input acceptance to o_out_valid an item passes the registered ring
//  reads, then the tap add into the output register.
//  Three ring copies (one read port each, shared write) supply the three taps
//  together; a tap that points at the sample still being summed is
//  forwarded from the adder.
//  Reset is synchronous; no clearing pass. A wrap flag plus the write pointer
//  tell which ring slots were written since reset; others read as zero.
//  With the output register full and stalled, one more transaction is held in
//  the read stage, then o_in_stall rises.
// ----------------------------------------------------------------------------
module three_tap_feedback_echo #(
    parameter int RING_DEPTH = tfe_pkg::RING_DEPTH_DEFAULT
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,

    input  wire logic                                i_in_valid,
    output logic                                     o_in_stall,
    input  wire logic signed [tfe_pkg::SAMPLE_W-1:0] i_in_sample,

    output logic                                     o_out_valid,
    input  wire logic                                i_out_stall,
    output logic signed [tfe_pkg::SAMPLE_W-1:0]      o_out_sample,

    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [tfe_pkg::PADDR_W-1:0]         paddr,
    input  wire logic [tfe_pkg::PDATA_W-1:0]         pwdata,
    output logic [tfe_pkg::PDATA_W-1:0]              prdata,
    output logic                                     pready
);

    localparam int SW = tfe_pkg::SAMPLE_W;
    localparam int DW = tfe_pkg::DELAY_W;
    localparam int NT = tfe_pkg::NUM_TAPS;
    localparam int AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;

    localparam logic [AW:0]   DEPTH_X = (AW+1)'(RING_DEPTH);
    localparam logic [AW-1:0] LAST    = AW'(RING_DEPTH - 1);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic          cfg_we;
    logic [1:0]    cfg_idx;
    logic [DW-1:0] r_delay [NT];

    assign pready  = 1'b1;
    assign cfg_we  = psel & penable & pwrite & pready;
    assign cfg_idx = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay[0] <= tfe_pkg::TAP_DELAY_ONE_RST;
            r_delay[1] <= tfe_pkg::TAP_DELAY_TWO_RST;
            r_delay[2] <= tfe_pkg::TAP_DELAY_THREE_RST;
        end else if (cfg_we) begin
            unique case (cfg_idx)
                tfe_pkg::REG_TAP_DELAY_ONE:   r_delay[0] <= pwdata[DW-1:0];
                tfe_pkg::REG_TAP_DELAY_TWO:   r_delay[1] <= pwdata[DW-1:0];
                tfe_pkg::REG_TAP_DELAY_THREE: r_delay[2] <= pwdata[DW-1:0];
                default: ;  // unmapped address: write dropped
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            tfe_pkg::REG_TAP_DELAY_ONE:   prdata = tfe_pkg::PDATA_W'(r_delay[0]);
            tfe_pkg::REG_TAP_DELAY_TWO:   prdata = tfe_pkg::PDATA_W'(r_delay[1]);
            tfe_pkg::REG_TAP_DELAY_THREE: prdata = tfe_pkg::PDATA_W'(r_delay[2]);
            default:                      prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Delay folded into the ring: back = delay mod RING_DEPTH
    // ------------------------------------------------------------------
    logic [AW-1:0] back [NT];

    generate
        if (RING_DEPTH > (1 << DW) - 1) begin : g_wide
            // every legal delay is already below the ring depth
            for (genvar j = 0; j < NT; j++) begin : g_tap
                assign back[j] = AW'(r_delay[j]);
            end
        end else begin : g_fold
            // quotient taken by reciprocal at write time (exact for 10-bit
            // delays and depths below 1024), remainder formed on the fly
            localparam int RS = tfe_pkg::RECIP_SHIFT;
            localparam logic [RS+DW-1:0] RECIP =
                (RS+DW)'(((1 << RS) + RING_DEPTH - 1) / RING_DEPTH);

            logic [RS+DW-1:0] wr_prod;
            logic [DW-1:0]    r_quot [NT];

            assign wr_prod = (RS+DW)'(pwdata[DW-1:0]) * RECIP;

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_quot[0] <= DW'(tfe_pkg::TAP_DELAY_ONE_RST   / RING_DEPTH);
                    r_quot[1] <= DW'(tfe_pkg::TAP_DELAY_TWO_RST   / RING_DEPTH);
                    r_quot[2] <= DW'(tfe_pkg::TAP_DELAY_THREE_RST / RING_DEPTH);
                end else if (cfg_we) begin
                    unique case (cfg_idx)
                        tfe_pkg::REG_TAP_DELAY_ONE:   r_quot[0] <= wr_prod[RS+DW-1:RS];
                        tfe_pkg::REG_TAP_DELAY_TWO:   r_quot[1] <= wr_prod[RS+DW-1:RS];
                        tfe_pkg::REG_TAP_DELAY_THREE: r_quot[2] <= wr_prod[RS+DW-1:RS];
                        default: ;
                    endcase
                end
            end

            for (genvar j = 0; j < NT; j++) begin : g_tap
                logic [2*DW-1:0] rem;
                assign rem = (2*DW)'(r_delay[j])
                           - (2*DW)'(r_quot[j]) * (2*DW)'(RING_DEPTH);
                assign back[j] = rem[AW-1:0];
            end
        end
    endgenerate

    // ------------------------------------------------------------------
    // Handshake and pipeline control
    // ------------------------------------------------------------------
    logic          r_s1_valid;
    logic          r_out_valid;
    logic          s1_adv;
    logic          in_acc;

    assign s1_adv     = r_s1_valid & (~r_out_valid | ~i_out_stall);
    assign o_in_stall = r_s1_valid & r_out_valid & i_out_stall;
    assign in_acc     = i_in_valid & ~o_in_stall;

    // write pointer and fill tracking
    logic [AW-1:0] r_wp;
    logic          r_wrap;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= '0;
            r_wrap <= 1'b0;
        end else if (in_acc) begin
            if (r_wp == LAST) begin
                r_wp   <= '0;
                r_wrap <= 1'b1;
            end else begin
                r_wp <= r_wp + AW'(1);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: ring reads registered, then tap sum
    // ------------------------------------------------------------------
    logic signed [SW-1:0] r_s1_sample;
    logic [AW-1:0]        r_s1_wa;
    logic [SW-1:0]        r_rd   [NT];
    logic [NT-1:0]        r_ok;
    logic [NT-1:0]        r_fwd;
    logic [SW-1:0]        r_fwd_data;

    logic [AW-1:0]        rd_addr [NT];
    logic [NT-1:0]        rd_ok;
    logic [NT-1:0]        rd_fwd;
    logic signed [SW-1:0] tap   [NT];
    logic signed [SW-1:0] sum;

    for (genvar j = 0; j < NT; j++) begin : g_addr
        logic [AW:0] diff;
        logic [AW:0] wrapped;
        assign diff       = {1'b0, r_wp} - {1'b0, back[j]};
        assign wrapped    = diff[AW] ? (diff + DEPTH_X) : diff;
        assign rd_addr[j] = wrapped[AW-1:0];
        // slot written since reset?
        assign rd_ok[j]   = r_wrap | (rd_addr[j] < r_wp);
        // slot still being written by the item in stage 1
        assign rd_fwd[j]  = s1_adv & (rd_addr[j] == r_s1_wa);
    end

    // three ring copies, identical contents, one read port each
    for (genvar j = 0; j < NT; j++) begin : g_ring
        logic [SW-1:0] mem [RING_DEPTH];

        always_ff @(posedge i_clk) begin
            if (s1_adv) begin
                mem[r_s1_wa] <= sum;
            end
            if (in_acc) begin
                r_rd[j] <= mem[rd_addr[j]];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_acc) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_sample <= i_in_sample;
            r_s1_wa     <= r_wp;
            r_ok        <= rd_ok;
            r_fwd       <= rd_fwd;
            r_fwd_data  <= sum;
        end
    end

    always_comb begin
        for (int j = 0; j < NT; j++) begin
            if (r_s1_sample == '0) begin
                tap[j] = '0;
            end else if (r_fwd[j]) begin
                tap[j] = tfe_pkg::div4_trunc($signed(r_fwd_data));
            end else if (r_ok[j]) begin
                tap[j] = tfe_pkg::div4_trunc($signed(r_rd[j]));
            end else begin
                tap[j] = '0;
            end
        end
        // 16-bit wrap on purpose
        sum = r_s1_sample + tap[0] + tap[1] + tap[2];
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    logic signed [SW-1:0] r_out_sample;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_sample <= sum;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_sample = r_out_sample;

endmodule
`default_nettype wire

// File: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the three-tap feedback echo. A local echo model is
// updated for every accepted input transaction, and each output transaction is
// compared with the oldest queued prediction. Tap delays are set over APB while
// the block is idle. The run covers register access, directed extremes, random
// phases (mostly with random idling on both channels), and a long output
// hold-off that forces the block to back-pressure its input.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int SAMPLE_W     = tfe_pkg::SAMPLE_W;
    localparam int DELAY_W      = tfe_pkg::DELAY_W;
    localparam int NUM_TAPS     = tfe_pkg::NUM_TAPS;
    localparam int PADDR_W      = tfe_pkg::PADDR_W;
    localparam int PDATA_W      = tfe_pkg::PDATA_W;
    localparam int RING_DEPTH   = tfe_pkg::RING_DEPTH_DEFAULT;
    localparam int PTR_W        = $clog2(RING_DEPTH);
    localparam int RESET_CYCLES = 6;
    localparam int DRAIN_CYCLES = 4;      // leave some margin after the queue empties
    localparam int QUIET_LIMIT  = 2000;   // well beyond the longest hold-off, HOLD_CYCLES
    localparam int HOLD_CYCLES  = 200;

    // register index with no register behind it; writes must be dropped
    localparam logic [1:0] REG_UNMAPPED = 2'd3;

    // ------------------------------------------------------------------
    // DUT signals
    // ------------------------------------------------------------------
    logic                        i_clk;
    logic                        i_rst_n;
    logic                        i_in_valid;
    logic                        o_in_stall;
    logic signed [SAMPLE_W-1:0]  i_in_sample;
    logic                        o_out_valid;
    logic                        i_out_stall;
    logic signed [SAMPLE_W-1:0]  o_out_sample;
    logic                        psel;
    logic                        penable;
    logic                        pwrite;
    logic [PADDR_W-1:0]          paddr;
    logic [PDATA_W-1:0]          pwdata;
    logic [PDATA_W-1:0]          prdata;
    logic                        pready;

    three_tap_feedback_echo #(
        .RING_DEPTH(RING_DEPTH)
    ) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_sample (i_in_sample),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_sample(o_out_sample),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // ------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------
    int n_errors     = 0;
    int tx_idle_pct  = 0;    // chance per cycle that the sender idles
    int rx_idle_pct  = 0;    // chance per cycle that the receiver stalls
    int hold_request = 0;    // hold-off length handed to the stall process
    int hold_left    = 0;
    int quiet_cycles = 0;

    // predictions waiting for their output transaction, oldest first
    logic signed [SAMPLE_W-1:0] echo_expected [$];
    logic signed [SAMPLE_W-1:0] echo_oldest;

    // local copy of the echo state and the tap delays
    logic signed [SAMPLE_W-1:0] echo_ring [RING_DEPTH];
    logic [PTR_W-1:0]           ring_wr_ptr;
    logic [DELAY_W-1:0]         tap_delay [NUM_TAPS];

    // ------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------
    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // ------------------------------------------------------------------
    // Echo model
    // ------------------------------------------------------------------
    function automatic void echo_reset();
        foreach (echo_ring[i]) echo_ring[i] = '0;
        ring_wr_ptr  = '0;
        tap_delay[0] = tfe_pkg::TAP_DELAY_ONE_RST;
        tap_delay[1] = tfe_pkg::TAP_DELAY_TWO_RST;
        tap_delay[2] = tfe_pkg::TAP_DELAY_THREE_RST;
    endfunction

    // only the low DELAY_W bits of a write are kept; unknown indexes drop it
    function automatic void echo_set_delay(input logic [1:0] index,
                                           input logic [PDATA_W-1:0] data);
        unique case (index)
            tfe_pkg::REG_TAP_DELAY_ONE:   tap_delay[0] = data[DELAY_W-1:0];
            tfe_pkg::REG_TAP_DELAY_TWO:   tap_delay[1] = data[DELAY_W-1:0];
            tfe_pkg::REG_TAP_DELAY_THREE: tap_delay[2] = data[DELAY_W-1:0];
            default: ;
        endcase
    endfunction

    // One sample through the comb: taps read past outputs (pointer arithmetic
    // wraps at the ring depth, so a zero delay hits the slot about to be
    // overwritten), each tap is divided by 4 toward zero, the sum wraps; a zero input mutes the taps.
    function automatic logic signed [SAMPLE_W-1:0] echo_next(
        input logic signed [SAMPLE_W-1:0] x
    );
        int                         acc;
        logic [PTR_W-1:0]           slot;
        logic signed [SAMPLE_W-1:0] y;
        acc = int'(x);
        if (x != 0) begin
            for (int k = 0; k < NUM_TAPS; k++) begin
                slot = ring_wr_ptr - PTR_W'(tap_delay[k]);
                acc += int'(echo_ring[slot]) / 4;
            end
        end
        y = acc[SAMPLE_W-1:0];
        echo_ring[ring_wr_ptr] = y;
        ring_wr_ptr = ring_wr_ptr + PTR_W'(1);
        return y;
    endfunction

    // mostly full-range noise, with zeros, rails and small values mixed in
    function automatic logic signed [SAMPLE_W-1:0] random_sample();
        unique case ($urandom_range(0, 9))
            0:       return '0;
            1:       return ($urandom_range(0, 1) != 0) ? 16'sh7FFF : 16'sh8000;
            2:       return SAMPLE_W'($signed($urandom_range(0, 128)) - 64);
            default: return SAMPLE_W'($urandom());
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Input channel driver
    // ------------------------------------------------------------------
    // Valid stays high between back-to-back transactions; an idle stretch
    // lowers it in one step and raises it in a later one.
    task automatic send_sample(input logic signed [SAMPLE_W-1:0] x);
        if (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < tx_idle_pct);
        end
        i_in_valid  <= 1'b1;
        i_in_sample <= x;
        do @(posedge i_clk); while (o_in_stall);
        echo_expected.push_back(echo_next(x));
    endtask

    // Stop offering, then wait for every prediction to be matched.
    task automatic wait_for_drain();
        i_in_valid <= 1'b0;
        while (echo_expected.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // APB access
    // ------------------------------------------------------------------
    // Each access ends with the bus returned to idle before the task returns.
    task automatic apb_write(input logic [1:0] index, input logic [PDATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        echo_set_delay(index, data);
        @(posedge i_clk);
    endtask

    task automatic apb_check_read(input logic [1:0] index, input logic [DELAY_W-1:0] want);
        logic [PDATA_W-1:0] got;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {index, 2'b00};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        got = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (got !== PDATA_W'(want)) begin
            $error("prdata[reg %0d]: expected %0d, got %0d", index, want, got);
            n_errors++;
        end
        @(posedge i_clk);
    endtask

    // Block must be idle here. Upper data bits are random to show masking;
    // the unmapped index gets a junk write every time.
    task automatic configure_delays(input logic [DELAY_W-1:0] d1,
                                    input logic [DELAY_W-1:0] d2,
                                    input logic [DELAY_W-1:0] d3);
        logic [PDATA_W-1:0] junk;
        wait_for_drain();
        junk = $urandom();
        apb_write(tfe_pkg::REG_TAP_DELAY_ONE,   {junk[PDATA_W-1:DELAY_W], d1});
        junk = $urandom();
        apb_write(tfe_pkg::REG_TAP_DELAY_TWO,   {junk[PDATA_W-1:DELAY_W], d2});
        junk = $urandom();
        apb_write(tfe_pkg::REG_TAP_DELAY_THREE, {junk[PDATA_W-1:DELAY_W], d3});
        apb_write(REG_UNMAPPED, $urandom());
    endtask

    // ------------------------------------------------------------------
    // Output channel: stall generator and checker
    // ------------------------------------------------------------------
    // A hold-off request is counted down here, in cycles, independent of
    // the sender.
    always @(posedge i_clk) begin
        if (hold_request != 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            i_out_stall <= 1'b1;
            hold_left--;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (echo_expected.size() == 0) begin
                $error("out_sample: unexpected transaction, got %0d", o_out_sample);
                n_errors++;
            end else begin
                echo_oldest = echo_expected.pop_front();
                if (o_out_sample !== echo_oldest) begin
                    $error("out_sample: expected %0d, got %0d", echo_oldest, o_out_sample);
                    n_errors++;
                end
            end
        end
    end

    // Watchdog: any transaction or APB access counts as progress.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (psel && penable)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("FAIL three_tap_feedback_echo");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Reset values, dropped write to the unmapped index, masking of the
    // upper data bits.
    task automatic test_register_access();
        apb_check_read(tfe_pkg::REG_TAP_DELAY_ONE,   tfe_pkg::TAP_DELAY_ONE_RST);
        apb_check_read(tfe_pkg::REG_TAP_DELAY_TWO,   tfe_pkg::TAP_DELAY_TWO_RST);
        apb_check_read(tfe_pkg::REG_TAP_DELAY_THREE, tfe_pkg::TAP_DELAY_THREE_RST);
        apb_write(REG_UNMAPPED, '1);
        apb_check_read(tfe_pkg::REG_TAP_DELAY_ONE,   tfe_pkg::TAP_DELAY_ONE_RST);
        apb_check_read(tfe_pkg::REG_TAP_DELAY_TWO,   tfe_pkg::TAP_DELAY_TWO_RST);
        apb_check_read(tfe_pkg::REG_TAP_DELAY_THREE, tfe_pkg::TAP_DELAY_THREE_RST);
        apb_write(tfe_pkg::REG_TAP_DELAY_TWO, 32'hFFFF_FC07);
        apb_check_read(tfe_pkg::REG_TAP_DELAY_TWO, 10'd7);
    endtask

    // Short taps so the feedback builds fast: rails push the sum past 16
    // bits, zero input must mute the taps, small negatives check truncation.
    task automatic test_directed_extremes();
        logic signed [SAMPLE_W-1:0] vec [$];
        vec = '{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF,
                16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
                16'sd0, 16'sd1, -16'sd1, -16'sd2, 16'sd2, 16'sd3, -16'sd3, 16'sd0,
                16'sh5555, 16'shAAAA, 16'sd255, -16'sd256, 16'sd0, 16'sh7FFF};
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        configure_delays(10'd1, 10'd2, 10'd3);
        foreach (vec[i]) send_sample(vec[i]);
    endtask

    task automatic test_random_phase(input int tx_pct, input int rx_pct,
                                     input logic [DELAY_W-1:0] d1,
                                     input logic [DELAY_W-1:0] d2,
                                     input logic [DELAY_W-1:0] d3,
                                     input int count);
        configure_delays(d1, d2, d3);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        repeat (count) send_sample(random_sample());
    endtask

    // Receiver holds off while the sender keeps offering: the block fills
    // and must stall its input. Then the sender pauses until all drain.
    task automatic test_backpressure();
        configure_delays(DELAY_W'($urandom()), DELAY_W'($urandom()), DELAY_W'($urandom()));
        tx_idle_pct  = 0;
        rx_idle_pct  = 0;
        hold_request = HOLD_CYCLES;
        repeat (24) send_sample(random_sample());
        wait_for_drain();
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in_sample <= '0;
        i_out_stall <= 1'b0;
        psel        <= 1'b0;
        penable     <= 1'b0;
        pwrite      <= 1'b0;
        paddr       <= '0;
        pwdata      <= '0;
        echo_reset();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_register_access();
        test_directed_extremes();
        // sender idles less than receiver, short random taps
        test_random_phase(29, 67, DELAY_W'($urandom_range(1, 64)),
                          DELAY_W'($urandom_range(1, 64)),
                          DELAY_W'($urandom_range(1, 64)), 420);
        // receiver idles less than sender, taps anywhere in the ring
        test_random_phase(67, 29, DELAY_W'($urandom()), DELAY_W'($urandom()),
                          DELAY_W'($urandom()), 420);
        // no idling; zero delay and full-span delay once the ring has wrapped
        test_random_phase(0, 0, 10'd0, 10'd1023, 10'd1, 420);
        test_backpressure();

        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("PASS three_tap_feedback_echo");
        end else begin
            $display("FAIL three_tap_feedback_echo");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/tfe_pkg.sv
rtl/three_tap_feedback_echo.sv
tb/sv/tb_top.sv
